// ===== sv/dwc_pkg.sv =====
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared types, constants and command/status structs of the decimal word
// machine execute unit.
// ----------------------------------------------------------------------------
package dwc_pkg;

  localparam int unsigned DEF_MEM_DEPTH = 1048576;
  localparam int unsigned DEF_NUM_REGS  = 9;

  localparam logic [19:0] RESET_PC = 20'd100;

  // Request kinds
  localparam logic [1:0] ITEM_LOAD  = 2'd0;
  localparam logic [1:0] ITEM_START = 2'd1;
  localparam logic [1:0] ITEM_EXEC  = 2'd2;
  localparam logic [1:0] ITEM_NOP   = 2'd3;

  // Instruction operation codes
  localparam logic [4:0] OP_NONE  = 5'd0;
  localparam logic [4:0] OP_ADD   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_MUL   = 5'd3;
  localparam logic [4:0] OP_DIV   = 5'd4;
  localparam logic [4:0] OP_LOAD  = 5'd5;
  localparam logic [4:0] OP_STORE = 5'd6;
  localparam logic [4:0] OP_RADD  = 5'd7;
  localparam logic [4:0] OP_RSUB  = 5'd8;
  localparam logic [4:0] OP_RMUL  = 5'd9;
  localparam logic [4:0] OP_RDIV  = 5'd10;
  localparam logic [4:0] OP_READ  = 5'd11;
  localparam logic [4:0] OP_WRITE = 5'd12;
  localparam logic [4:0] OP_JUMP  = 5'd13;
  localparam logic [4:0] OP_BNEG  = 5'd14;
  localparam logic [4:0] OP_BZERO = 5'd15;
  localparam logic [4:0] OP_BPOS  = 5'd16;
  localparam logic [4:0] OP_HALT  = 5'd17;

  // Result status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_HALT = 3'd1;
  localparam logic [2:0] ST_DIV0 = 3'd2;
  localparam logic [2:0] ST_ADDR = 3'd3;
  localparam logic [2:0] ST_REG  = 3'd4;

  // Decimal decode scales; words at or above WORD_LIMIT decode past halt
  localparam logic [27:0] SCALE_OP   = 28'd10000000;
  localparam logic [27:0] SCALE_R    = 28'd1000000;
  localparam logic [27:0] SCALE_S    = 28'd100000;
  localparam logic [63:0] WORD_LIMIT = 64'd180000000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [19:0]        load_address;
    logic signed [63:0] data_value;
  } dwc_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [63:0] write_value;
    logic               write_valid;
    logic [19:0]        next_pc;
  } dwc_out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_FETCH, S_DOP, S_DR, S_DS, S_CHECK,
    S_OPND, S_ALU, S_RUN, S_WB, S_WRITE, S_FIN
  } dwc_state_e;

  typedef enum logic [1:0] {MA_PC, MA_OPND, MA_LOAD, MA_CLR} mem_addr_e;
  typedef enum logic [1:0] {MW_DATA, MW_REG, MW_ZERO} mem_wdata_e;
  typedef enum logic [1:0] {DEC_OP, DEC_R, DEC_S} dec_phase_e;
  typedef enum logic [2:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_PASS} alu_e;
  typedef enum logic [1:0] {PC_INC, PC_JUMP, PC_START} pc_sel_e;

  typedef struct packed {
    logic       latch_in;
    mem_addr_e  mem_addr;
    logic       mem_rd;
    logic       mem_we;
    mem_wdata_e mem_wdata;
    logic       word_ld;
    logic       dec_step;
    dec_phase_e dec_phase;
    logic       rf_rd;
    logic       rf_clr;
    logic       opnd_ld;
    logic       b_from_reg;
    logic       alu_start;
    alu_e       alu_op;
    logic       alu_step;
    logic       rf_wb;
    logic       lr_clr;
    logic       pc_ld;
    pc_sel_e    pc_sel;
    logic       halt_set;
    logic       halt_clr;
    logic       out_ld;
    logic [2:0] out_status;
    logic       out_wv;
  } dwc_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [1:0] opcode;
    logic       la_ge;
    logic       halted;
    logic       pc_ge;
    logic       word_big;
    logic       dec_done;
    logic [4:0] op;
    logic       addr_ge;
    logic       r_ge;
    logic       s_ge;
    logic       b_zero;
    logic       alu_done;
    logic       lr_neg;
    logic       lr_zero;
    logic       out_free;
  } dwc_sts_t;

endpackage

// ===== sv/dwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwc_ctrl
// Sequencer: memory clear after reset, request dispatch, instruction fetch,
// decimal decode, checks, execution and result hand-off.
// ----------------------------------------------------------------------------
module dwc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dwc_pkg::dwc_sts_t sts_i,
  output dwc_pkg::dwc_cmd_t cmd_o
);
  import dwc_pkg::*;

  dwc_state_e state_q, state_d;
  logic [2:0] st_q, st_d;
  logic       wv_q, wv_d;
  logic       take;

  // State and pending result code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      st_q    <= ST_OK;
      wv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      wv_q    <= wv_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  assign take = (sts_i.op == OP_JUMP) ||
                ((sts_i.op == OP_BNEG) && sts_i.lr_neg) ||
                ((sts_i.op == OP_BZERO) && sts_i.lr_zero) ||
                ((sts_i.op == OP_BPOS) && !sts_i.lr_neg && !sts_i.lr_zero);

  // Next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    st_d    = st_q;
    wv_d    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_addr  = MA_CLR;
        cmd_o.mem_wdata = MW_ZERO;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_FIN;
        st_d    = ST_OK;
        case (sts_i.opcode)
          ITEM_LOAD: begin
            if (sts_i.la_ge) begin
              st_d = ST_ADDR;
            end else begin
              cmd_o.mem_we    = 1'b1;
              cmd_o.mem_addr  = MA_LOAD;
              cmd_o.mem_wdata = MW_DATA;
            end
          end
          ITEM_START: begin
            cmd_o.rf_clr   = 1'b1;
            cmd_o.lr_clr   = 1'b1;
            cmd_o.halt_clr = 1'b1;
            cmd_o.pc_ld    = 1'b1;
            cmd_o.pc_sel   = PC_START;
          end
          ITEM_EXEC: begin
            if (sts_i.halted) begin
              st_d = ST_HALT;
            end else if (sts_i.pc_ge) begin
              cmd_o.halt_set = 1'b1;
              st_d           = ST_ADDR;
            end else begin
              cmd_o.mem_rd   = 1'b1;
              cmd_o.mem_addr = MA_PC;
              state_d        = S_FETCH;
            end
          end
          default: st_d = ST_OK;
        endcase
      end
      S_FETCH: begin
        cmd_o.word_ld = 1'b1;
        state_d       = S_DOP;
      end
      S_DOP: begin
        if (sts_i.word_big) begin
          cmd_o.pc_ld = 1'b1;
          st_d        = ST_OK;
          state_d     = S_FIN;
        end else begin
          cmd_o.dec_step  = 1'b1;
          cmd_o.dec_phase = DEC_OP;
          if (sts_i.dec_done) state_d = S_DR;
        end
      end
      S_DR: begin
        cmd_o.dec_step  = 1'b1;
        cmd_o.dec_phase = DEC_R;
        if (sts_i.dec_done) state_d = S_DS;
      end
      S_DS: begin
        cmd_o.dec_step  = 1'b1;
        cmd_o.dec_phase = DEC_S;
        if (sts_i.dec_done) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_FIN;
        st_d    = ST_OK;
        if (sts_i.op == OP_HALT) begin
          cmd_o.halt_set = 1'b1;
          st_d           = ST_HALT;
        end else if (sts_i.op == OP_NONE) begin
          cmd_o.pc_ld = 1'b1;
        end else if ((sts_i.op <= OP_STORE || sts_i.op >= OP_READ) && sts_i.addr_ge) begin
          cmd_o.halt_set = 1'b1;
          st_d           = ST_ADDR;
        end else if (sts_i.op <= OP_RDIV && sts_i.r_ge) begin
          cmd_o.halt_set = 1'b1;
          st_d           = ST_REG;
        end else if (sts_i.op >= OP_RADD && sts_i.op <= OP_RDIV && sts_i.s_ge) begin
          cmd_o.halt_set = 1'b1;
          st_d           = ST_REG;
        end else if (sts_i.op <= OP_RDIV) begin
          cmd_o.mem_rd   = 1'b1;
          cmd_o.mem_addr = MA_OPND;
          cmd_o.rf_rd    = 1'b1;
          state_d        = S_OPND;
        end else if (sts_i.op == OP_READ) begin
          cmd_o.mem_we    = 1'b1;
          cmd_o.mem_addr  = MA_OPND;
          cmd_o.mem_wdata = MW_DATA;
          cmd_o.pc_ld     = 1'b1;
        end else if (sts_i.op == OP_WRITE) begin
          cmd_o.mem_rd   = 1'b1;
          cmd_o.mem_addr = MA_OPND;
          state_d        = S_WRITE;
        end else begin
          cmd_o.pc_ld  = 1'b1;
          cmd_o.pc_sel = take ? PC_JUMP : PC_INC;
        end
      end
      S_OPND: begin
        if (sts_i.op == OP_STORE) begin
          cmd_o.mem_we    = 1'b1;
          cmd_o.mem_addr  = MA_OPND;
          cmd_o.mem_wdata = MW_REG;
          cmd_o.pc_ld     = 1'b1;
          st_d            = ST_OK;
          state_d         = S_FIN;
        end else begin
          cmd_o.opnd_ld    = 1'b1;
          cmd_o.b_from_reg = (sts_i.op >= OP_RADD);
          state_d          = S_ALU;
        end
      end
      S_ALU: begin
        if ((sts_i.op == OP_DIV || sts_i.op == OP_RDIV) && sts_i.b_zero) begin
          cmd_o.halt_set = 1'b1;
          st_d           = ST_DIV0;
          state_d        = S_FIN;
        end else begin
          cmd_o.alu_start = 1'b1;
          case (sts_i.op)
            OP_ADD, OP_RADD: cmd_o.alu_op = ALU_ADD;
            OP_SUB, OP_RSUB: cmd_o.alu_op = ALU_SUB;
            OP_MUL, OP_RMUL: cmd_o.alu_op = ALU_MUL;
            OP_DIV, OP_RDIV: cmd_o.alu_op = ALU_DIV;
            default:         cmd_o.alu_op = ALU_PASS;
          endcase
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (sts_i.alu_done) state_d = S_WB;
        else cmd_o.alu_step = 1'b1;
      end
      S_WB: begin
        cmd_o.rf_wb = 1'b1;
        cmd_o.pc_ld = 1'b1;
        st_d        = ST_OK;
        state_d     = S_FIN;
      end
      S_WRITE: begin
        cmd_o.pc_ld = 1'b1;
        st_d        = ST_OK;
        wv_d        = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        wv_d             = wv_q;
        cmd_o.out_status = st_q;
        cmd_o.out_wv     = wv_q;
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== sv/dwc_datapath.sv =====
// ----------------------------------------------------------------------------
// dwc_datapath
// Main memory, register file, decimal decoder, add/multiply/divide unit,
// program counter, flags and the result register.
// ----------------------------------------------------------------------------
module dwc_datapath #(
  parameter int unsigned MEM_DEPTH = dwc_pkg::DEF_MEM_DEPTH,
  parameter int unsigned NUM_REGS  = dwc_pkg::DEF_NUM_REGS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dwc_pkg::dwc_in_t  in_data_i,
  input  logic              cfg_we_i,
  input  logic [19:0]       cfg_wdata_i,
  input  dwc_pkg::dwc_cmd_t cmd_i,
  output dwc_pkg::dwc_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dwc_pkg::dwc_out_t out_data_o
);
  import dwc_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MEM_DEPTH);
  localparam int unsigned RIDX_W = $clog2(NUM_REGS);
  localparam logic [20:0] DEPTH_V = 21'(MEM_DEPTH);
  localparam logic [3:0]  REGS_V  = 4'(NUM_REGS);

  logic [19:0]       start_q;
  dwc_in_t           item_q;
  logic [ADDR_W-1:0] clr_q;
  logic [63:0]       mem [MEM_DEPTH];
  logic [63:0]       mem_rd_q;
  logic [ADDR_W-1:0] mem_a;
  logic [63:0]       mem_wd;
  logic [19:0]       pc_q, pc_d;
  logic              halted_q;
  logic [63:0]       lr_q;
  logic              word_big_q;
  logic [27:0]       rem_q, scale;
  logic [4:0]        op_q;
  logic [3:0]        r_q, s_q;
  logic [19:0]       addr_q;
  logic              dec_ge;
  logic [63:0]       rf [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_q;
  logic [RIDX_W-1:0] ra, rb;
  logic [63:0]       rd_a_q, rd_b_q;
  logic [63:0]       a_q, b_q;
  alu_e              alu_q;
  logic [6:0]        cnt_q;
  logic [63:0]       acc_q, p0_q, p1_q, p2_q;
  logic [31:0]       mul_x, mul_y;
  logic [63:0]       prod;
  logic [63:0]       dq_q, dr_q, dm_q;
  logic              dneg_q;
  logic [64:0]       ddiff;
  logic [63:0]       alu_res;
  logic              out_valid_q;
  dwc_out_t          out_q;

  // Start address register and request capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) start_q <= RESET_PC;
    else if (cfg_we_i) start_q <= cfg_wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) item_q <= in_data_i;
  end

  // Clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.mem_we && cmd_i.mem_addr == MA_CLR) clr_q <= clr_q + 1'b1;
  end

  // Main memory: one port, registered read
  always_comb begin
    case (cmd_i.mem_addr)
      MA_PC:   mem_a = pc_q[ADDR_W-1:0];
      MA_OPND: mem_a = addr_q[ADDR_W-1:0];
      MA_LOAD: mem_a = item_q.load_address[ADDR_W-1:0];
      MA_CLR:  mem_a = clr_q;
      default: mem_a = clr_q;
    endcase
    case (cmd_i.mem_wdata)
      MW_DATA: mem_wd = item_q.data_value;
      MW_REG:  mem_wd = rd_a_q;
      default: mem_wd = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem[mem_a] <= mem_wd;
    if (cmd_i.mem_rd) mem_rd_q <= mem[mem_a];
  end

  // Program counter, halt flag and last result
  always_comb begin
    case (cmd_i.pc_sel)
      PC_JUMP:  pc_d = addr_q;
      PC_START: pc_d = start_q;
      default:  pc_d = pc_q + 20'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= RESET_PC;
      halted_q <= 1'b0;
      lr_q     <= '0;
    end else begin
      if (cmd_i.pc_ld) pc_q <= pc_d;
      if (cmd_i.halt_set) halted_q <= 1'b1;
      else if (cmd_i.halt_clr) halted_q <= 1'b0;
      if (cmd_i.lr_clr) lr_q <= '0;
      else if (cmd_i.rf_wb) lr_q <= alu_res;
    end
  end

  // Decimal decode: one subtraction of the current scale per cycle
  always_comb begin
    case (cmd_i.dec_phase)
      DEC_OP:  scale = SCALE_OP;
      DEC_R:   scale = SCALE_R;
      default: scale = SCALE_S;
    endcase
  end
  assign dec_ge = (rem_q >= scale);

  always_ff @(posedge clk_i) begin
    if (cmd_i.word_ld) begin
      word_big_q <= mem_rd_q[63] || (mem_rd_q >= WORD_LIMIT);
      rem_q      <= mem_rd_q[27:0];
      op_q       <= '0;
      r_q        <= '0;
      s_q        <= '0;
    end else if (cmd_i.dec_step) begin
      if (dec_ge) begin
        rem_q <= rem_q - scale;
        case (cmd_i.dec_phase)
          DEC_OP:  op_q <= op_q + 5'd1;
          DEC_R:   r_q  <= r_q + 4'd1;
          default: s_q  <= s_q + 4'd1;
        endcase
      end else if (cmd_i.dec_phase == DEC_R) begin
        addr_q <= rem_q[19:0];
      end
    end
  end

  // Register file with valid bits; unwritten entries read as zero
  assign ra = r_q[RIDX_W-1:0];
  assign rb = s_q[RIDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rf_vld_q <= '0;
    else if (cmd_i.rf_clr) rf_vld_q <= '0;
    else if (cmd_i.rf_wb) rf_vld_q[ra] <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rf_wb) rf[ra] <= alu_res;
    if (cmd_i.rf_rd) begin
      rd_a_q <= rf_vld_q[ra] ? rf[ra] : '0;
      rd_b_q <= rf_vld_q[rb] ? rf[rb] : '0;
    end
  end

  // Operand capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.opnd_ld) begin
      a_q <= rd_a_q;
      b_q <= cmd_i.b_from_reg ? rd_b_q : mem_rd_q;
    end
  end

  // Shared 32x32 multiplier, one partial product per step
  always_comb begin
    case (cnt_q)
      7'd3:    begin mul_x = a_q[31:0];  mul_y = b_q[31:0];  end
      7'd2:    begin mul_x = a_q[31:0];  mul_y = b_q[63:32]; end
      default: begin mul_x = a_q[63:32]; mul_y = b_q[31:0];  end
    endcase
  end
  assign prod  = 64'(mul_x) * 64'(mul_y);
  assign ddiff = {1'b0, dr_q[62:0], dq_q[63]} - {1'b0, dm_q};

  // Arithmetic unit: add/sub at start, multiply in three partial-product steps, divide in 64 steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.alu_start) begin
      case (cmd_i.alu_op)
        ALU_MUL: cnt_q <= 7'd3;
        ALU_DIV: cnt_q <= 7'd64;
        default: cnt_q <= 7'd0;
      endcase
    end else if (cmd_i.alu_step) cnt_q <= cnt_q - 7'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alu_start) begin
      alu_q <= cmd_i.alu_op;
      case (cmd_i.alu_op)
        ALU_ADD: acc_q <= a_q + b_q;
        ALU_SUB: acc_q <= a_q - b_q;
        ALU_DIV: begin
          dq_q   <= a_q[63] ? (64'd0 - a_q) : a_q;
          dm_q   <= b_q[63] ? (64'd0 - b_q) : b_q;
          dr_q   <= '0;
          dneg_q <= a_q[63] ^ b_q[63];
        end
        default: acc_q <= b_q;
      endcase
    end else if (cmd_i.alu_step) begin
      if (alu_q == ALU_MUL) begin
        case (cnt_q)
          7'd3:    p0_q <= prod;
          7'd2:    p1_q <= prod;
          default: p2_q <= prod;
        endcase
      end else begin
        // Restoring step: shift in next dividend bit, subtract if it fits
        if (!ddiff[64]) begin
          dr_q <= ddiff[63:0];
          dq_q <= {dq_q[62:0], 1'b1};
        end else begin
          dr_q <= {dr_q[62:0], dq_q[63]};
          dq_q <= {dq_q[62:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    case (alu_q)
      ALU_MUL: alu_res = p0_q + {p1_q[31:0] + p2_q[31:0], 32'd0};
      ALU_DIV: alu_res = dneg_q ? (64'd0 - dq_q) : dq_q;
      default: alu_res = acc_q;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_ld) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_q.status      <= cmd_i.out_status;
      out_q.write_value <= cmd_i.out_wv ? mem_rd_q : '0;
      out_q.write_valid <= cmd_i.out_wv;
      out_q.next_pc     <= pc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status back to the sequencer
  always_comb begin
    sts_o.clr_done = (clr_q == ADDR_W'(MEM_DEPTH - 1));
    sts_o.opcode   = item_q.opcode;
    sts_o.la_ge    = ({1'b0, item_q.load_address} >= DEPTH_V);
    sts_o.halted   = halted_q;
    sts_o.pc_ge    = ({1'b0, pc_q} >= DEPTH_V);
    sts_o.word_big = word_big_q;
    sts_o.dec_done = !dec_ge;
    sts_o.op       = op_q;
    sts_o.addr_ge  = ({1'b0, addr_q} >= DEPTH_V);
    sts_o.r_ge     = (r_q >= REGS_V);
    sts_o.s_ge     = (s_q >= REGS_V);
    sts_o.b_zero   = (b_q == 64'd0);
    sts_o.alu_done = (cnt_q == 7'd0);
    sts_o.lr_neg   = lr_q[63];
    sts_o.lr_zero  = (lr_q == 64'd0);
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

endmodule

// ===== sv/decimal_word_cpu_execute.sv =====
// ----------------------------------------------------------------------------
// decimal_word_cpu_execute: one request at a time. An execute request fetches a
// word, decodes the op, R and S digits by repeated subtraction, checks, executes;
// divide (64-step shift/subtract loop) is the worst case. A stalled result
// holds the unit until it is taken.
// Reset: memory clear sweep over all MEM_DEPTH words, input stalled meanwhile.
// ----------------------------------------------------------------------------
module decimal_word_cpu_execute #(
  parameter int unsigned MEM_DEPTH = dwc_pkg::DEF_MEM_DEPTH,
  parameter int unsigned NUM_REGS  = dwc_pkg::DEF_NUM_REGS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dwc_pkg::dwc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dwc_pkg::dwc_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [19:0]       cfg_wdata_i
);
  import dwc_pkg::*;

  dwc_cmd_t cmd;
  dwc_sts_t sts;

  dwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dwc_datapath #(
    .MEM_DEPTH (MEM_DEPTH),
    .NUM_REGS  (NUM_REGS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // One request in flight: a taken request blocks the next one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_valid |-> out_data_o.status == ST_OK)
    else $error("write output with error status");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_valid |-> out_data_o.write_value == 64'd0)
    else $error("write value not zero without write");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> !out_valid_o || !out_stall_i)
    else $error("result register overwritten while stalled");

endmodule
